### sv/sat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

  localparam int WINDOW_DEF = 64;
  localparam int ACK_BITS   = 32;
  localparam int SEQ_W      = 16;
  localparam int PROT_W     = 16;
  localparam int CNT_W      = 6;

  // One table entry: valid flag plus the full sequence as tag
  typedef struct packed {
    logic             vld;
    logic [SEQ_W-1:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;   // clear one table entry
    logic cap;   // capture the input item
    logic quo;   // register the slot quotient estimate
    logic exe;   // evaluate the item, record or start the retire scan
    logic scn;   // one retire scan step
    logic ld;    // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_end;
    logic take;
    logic scan_end;
    logic out_free;
  } sts_t;

  // Wrap-aware "a is newer than b"
  function automatic logic seq_newer(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d_ab;
    logic [SEQ_W-1:0] d_ba;
    d_ab = a - b;
    d_ba = b - a;
    if (a > b) begin
      return d_ab <= SEQ_W'(32768);
    end else if (a < b) begin
      return d_ba > SEQ_W'(32768);
    end else begin
      return 1'b0;
    end
  endfunction

endpackage

`default_nettype wire

### sv/sat_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sat_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/sat_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sat_ctrl
  import sat_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_end) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_SLOT;
      ST_SLOT:  state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = sts.take ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (sts.scan_end) state_nxt = ST_DONE;
      ST_DONE:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      ST_SLOT:  cmd.quo = 1'b1;
      ST_EXEC:  cmd.exe = 1'b1;
      ST_SCAN:  cmd.scn = 1'b1;
      ST_DONE:  cmd.ld  = sts.out_free;
      default:  cmd     = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/sat_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sat_dp
  import sat_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [PROT_W-1:0]   cfg_wr_data,
  input  wire logic                in_op,
  input  wire logic [PROT_W-1:0]   in_protocol,
  input  wire logic [SEQ_W-1:0]    in_seq,
  input  wire logic [SEQ_W-1:0]    in_ack_seq,
  input  wire logic [ACK_BITS-1:0] in_ack_bits,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_accepted,
  output logic                     out_ack_ignored,
  output logic [CNT_W-1:0]         out_acked_count,
  output logic                     out_missing_ack
);

  localparam int AW        = $clog2(WINDOW);
  localparam int RECIP     = 65536 / WINDOW;
  localparam int QW        = $clog2(RECIP + 1);
  localparam int LAST_SLOT = 65535 % WINDOW;
  localparam int KW        = $clog2(ACK_BITS + 2);
  localparam int BW        = $clog2(ACK_BITS);
  localparam int LW        = $clog2(ACK_BITS + 1);

  localparam logic [SEQ_W-1:0] WIN_V   = SEQ_W'(WINDOW);
  localparam logic [QW-1:0]    RECIP_V = QW'(RECIP);

  // Step a slot back by one sequence, following the 16-bit wrap
  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s,
                                             input logic [SEQ_W-1:0] q);
    logic [AW-1:0] r;
    if (q == '0) begin
      r = AW'(LAST_SLOT);
    end else if (s == '0) begin
      r = AW'(WINDOW - 1);
    end else begin
      r = s - AW'(1);
    end
    return r;
  endfunction

  // Configuration and item registers
  logic [PROT_W-1:0]   prot_id_r;
  logic                op_r;
  logic [PROT_W-1:0]   prot_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [SEQ_W-1:0]    ack_r;
  logic [ACK_BITS-1:0] bits_r;

  // Protocol state
  logic [SEQ_W-1:0]    remote_seq_r;
  logic [SEQ_W-1:0]    last_ack_r;
  logic                missing_r;

  // Slot computation
  logic [QW-1:0]       q_r;
  logic [SEQ_W-1:0]    x_c;
  logic [SEQ_W+QW-1:0] prod_c;
  logic [SEQ_W-1:0]    qw_c;
  logic [SEQ_W-1:0]    rem_c;
  logic [AW-1:0]       slot_c;

  // Retire scan
  logic [AW-1:0]       clr_addr_r;
  logic [KW-1:0]       k_r;
  logic [SEQ_W-1:0]    iss_seq_r;
  logic [AW-1:0]       iss_slot_r;
  logic [SEQ_W-1:0]    rd_seq_r;
  logic [AW-1:0]       rd_slot_r;
  logic                rd_en_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                acc_r;
  logic                ign_r;
  logic [BW-1:0]       bit_idx;
  logic                scan_more;
  logic                hit;

  // Decisions
  logic                hdr_ok;
  logic                ack_old;
  logic [SEQ_W-1:0]    am1;
  logic [LW-1:0]       lim_c;
  logic [ACK_BITS-1:0] mask_c;
  logic                miss_c;

  // Table
  logic                we;
  logic [AW-1:0]       waddr;
  entry_t              wdata;
  logic [AW-1:0]       raddr;
  entry_t              rdata;

  // Output stage
  logic                out_valid_r;
  logic                out_acc_r;
  logic                out_ign_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic                out_miss_r;

  assign x_c    = op_r ? ack_r : seq_r;
  assign prod_c = x_c * RECIP_V;
  assign qw_c   = SEQ_W'(q_r * WIN_V);
  assign rem_c  = x_c - qw_c;
  assign slot_c = (rem_c >= WIN_V) ? AW'(rem_c - WIN_V) : AW'(rem_c);

  assign hdr_ok  = op_r && (prot_r == prot_id_r) && seq_newer(seq_r, remote_seq_r);
  assign ack_old = !seq_newer(ack_r, last_ack_r) && (ack_r != last_ack_r);

  assign am1   = ack_r - SEQ_W'(1);
  assign lim_c = (ack_r == '0) ? '0 :
                 (am1 < SEQ_W'(ACK_BITS)) ? LW'(am1) : LW'(ACK_BITS);
  assign mask_c = (lim_c >= LW'(ACK_BITS)) ? '1 :
                  ((ACK_BITS'(1) << lim_c) - ACK_BITS'(1));
  assign miss_c = |(~bits_r & mask_c);

  assign bit_idx   = BW'(k_r - KW'(1));
  assign scan_more = (k_r <= KW'(ACK_BITS));
  assign hit       = cmd.scn && rd_en_r && rdata.vld && (rdata.tag == rd_seq_r);

  always_comb begin
    we    = 1'b0;
    waddr = rd_slot_r;
    wdata = '0;
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_addr_r;
    end else if (cmd.exe && !op_r) begin
      we        = 1'b1;
      waddr     = slot_c;
      wdata.vld = 1'b1;
      wdata.tag = seq_r;
    end else if (hit) begin
      we = 1'b1;
    end
  end

  assign raddr = cmd.exe ? slot_c : iss_slot_r;

  sat_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(WINDOW)
  ) u_tbl (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prot_id_r    <= '0;
      remote_seq_r <= '0;
      last_ack_r   <= '0;
      missing_r    <= 1'b0;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        prot_id_r <= cfg_wr_data;
      end
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.exe && hdr_ok) begin
        remote_seq_r <= seq_r;
        if (!ack_old) begin
          last_ack_r <= ack_r;
          missing_r  <= miss_c;
        end
      end
      if (cmd.ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= in_op;
      prot_r <= in_protocol;
      seq_r  <= in_seq;
      ack_r  <= in_ack_seq;
      bits_r <= in_ack_bits;
    end
    if (cmd.quo) begin
      q_r <= prod_c[SEQ_W +: QW];
    end
    if (cmd.exe) begin
      acc_r      <= hdr_ok;
      ign_r      <= hdr_ok && ack_old;
      cnt_r      <= '0;
      rd_seq_r   <= ack_r;
      rd_slot_r  <= slot_c;
      rd_en_r    <= 1'b1;
      iss_seq_r  <= am1;
      iss_slot_r <= slot_dec(slot_c, ack_r);
      k_r        <= KW'(1);
    end
    if (cmd.scn) begin
      if (hit) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (scan_more) begin
        rd_seq_r   <= iss_seq_r;
        rd_slot_r  <= iss_slot_r;
        rd_en_r    <= bits_r[bit_idx];
        iss_seq_r  <= iss_seq_r - SEQ_W'(1);
        iss_slot_r <= slot_dec(iss_slot_r, iss_seq_r);
        k_r        <= k_r + KW'(1);
      end else begin
        rd_en_r <= 1'b0;
      end
    end
    if (cmd.ld) begin
      out_acc_r  <= acc_r;
      out_ign_r  <= ign_r;
      out_cnt_r  <= cnt_r;
      out_miss_r <= missing_r;
    end
  end

  always_comb begin
    sts          = '0;
    sts.clr_end  = (clr_addr_r == AW'(WINDOW - 1));
    sts.take     = hdr_ok && !ack_old;
    sts.scan_end = !scan_more;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_ack_ignored = out_ign_r;
  assign out_acked_count = out_cnt_r;
  assign out_missing_ack = out_miss_r;

endmodule

`default_nettype wire

### sv/selective_ack_tracker.sv
// Selective acknowledgement tracker. A record transfer (in_op = 0) marks a
// sent sequence as outstanding in a WINDOW-entry table indexed by
// seq mod WINDOW. A header transfer (in_op = 1) is accepted when in_protocol
// matches the protocol id register and in_seq is wrap-aware newer than the
// stored remote sequence; a non-stale ack then retires in_ack_seq and every
// sequence in_ack_seq-1-i whose ack bit i is set, and updates the
// missing-ack flag. Every input transfer yields exactly one result transfer.
// Timing: items are handled one at a time. A record or a rejected/ignored
// header passes through the slot, evaluate and done states after capture;
// a processed header also runs the retire scan, which walks the 33 candidate
// sequences through the table's single read port one per cycle, with the
// invalidate write-back following in the cycle after the read. A new item is
// accepted while a finished result still waits in the output register.
// After reset every table entry is cleared before the first item is accepted;
// configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module selective_ack_tracker
  import sat_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Protocol id register
  input  wire logic                cfg_wr_en,
  input  wire logic [PROT_W-1:0]   cfg_wr_data,
  // Input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_op,
  input  wire logic [PROT_W-1:0]   in_protocol,
  input  wire logic [SEQ_W-1:0]    in_seq,
  input  wire logic [SEQ_W-1:0]    in_ack_seq,
  input  wire logic [ACK_BITS-1:0] in_ack_bits,
  // Result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_accepted,
  output logic                     out_ack_ignored,
  output logic [CNT_W-1:0]         out_acked_count,
  output logic                     out_missing_ack
);

  cmd_t cmd;
  sts_t sts;

  // Sequence the clear pass, capture, slot, evaluate, scan and result load
  sat_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Hold the table, protocol state and the output register
  sat_dp #(
    .WINDOW(WINDOW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_op          (in_op),
    .in_protocol    (in_protocol),
    .in_seq         (in_seq),
    .in_ack_seq     (in_ack_seq),
    .in_ack_bits    (in_ack_bits),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_ack_ignored(out_ack_ignored),
    .out_acked_count(out_acked_count),
    .out_missing_ack(out_missing_ack)
  );

endmodule

`default_nettype wire
